@@ rtl/core/u2u16_pkg.sv @@
// Package with the word types, the queue entry type and the code constants of the encoder.
package u2u16_pkg;

  localparam logic [31:0] HighFirst = 32'h0000_D800;
  localparam logic [31:0] LowFirst  = 32'h0000_DC00;
  localparam logic [31:0] SurMask   = 32'h0000_03FF;
  localparam logic [31:0] SuppFirst = 32'h0001_0000;
  localparam logic [31:0] SuppLast  = 32'h0010_FFFF;
  localparam logic [15:0] QMark     = 16'h003F;
  localparam logic [15:0] HighBase  = 16'hD800;
  localparam logic [15:0] LowBase   = 16'hDC00;

  typedef struct packed {
    logic [31:0] code_point;
    logic        end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        replaced;
    logic        last_unit;
    logic        string_done;
    logic        all_converted;
  } out_item_t;

  typedef struct packed {
    logic [2:0][15:0] units;
    logic [2:0]       rep;
    logic [1:0]       count;
    logic             eos;
    logic             all_conv;
  } rec_t;

endpackage

@@ rtl/core/u2u16_front.sv @@
// Front end: holds the mode and surrogate state and turns one word into a queue entry of units.
module u2u16_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_data_i,
  input  logic                accept_i,
  input  u2u16_pkg::in_item_t in_data_i,
  output logic                push_o,
  output u2u16_pkg::rec_t     rec_o
);
  import u2u16_pkg::*;

  logic        t16_q;
  logic        pv_q, pv_d;
  logic [15:0] ph_q, ph_d;
  logic        err_q, err_d;

  logic [31:0] code;
  logic        eos;
  logic        is_high, is_low;
  logic [31:0] v;
  logic [1:0]  n;
  rec_t        rec;

  assign code    = in_data_i.code_point;
  assign eos     = in_data_i.end_of_string;
  assign is_high = (code >= HighFirst) && (code <= (HighFirst | SurMask));
  assign is_low  = (code >= LowFirst) && (code <= (LowFirst | SurMask));
  assign v       = code - SuppFirst;

  always_comb begin
    rec  = '0;
    n    = 2'd0;
    pv_d = pv_q;
    ph_d = ph_q;
    if (is_high) begin
      if (pv_q) begin
        rec.units[n] = QMark;
        rec.rep[n]   = 1'b1;
        n            = n + 2'd1;
      end
      ph_d = code[15:0];
      pv_d = 1'b1;
    end else if (is_low) begin
      if (!pv_q) begin
        rec.units[n] = QMark;
        rec.rep[n]   = 1'b1;
        n            = n + 2'd1;
      end else begin
        rec.units[n] = ph_q;
        n            = n + 2'd1;
        rec.units[n] = code[15:0];
        n            = n + 2'd1;
        ph_d         = '0;
        pv_d         = 1'b0;
      end
    end else begin
      if (pv_q) begin
        rec.units[n] = QMark;
        rec.rep[n]   = 1'b1;
        n            = n + 2'd1;
        ph_d         = '0;
        pv_d         = 1'b0;
      end
      if (!t16_q && (code >= SuppFirst)) begin
        if (code > SuppLast) begin
          rec.units[n] = QMark;
          rec.rep[n]   = 1'b1;
          n            = n + 2'd1;
        end else begin
          rec.units[n] = HighBase | {6'd0, v[19:10]};
          n            = n + 2'd1;
          rec.units[n] = LowBase | {6'd0, v[9:0]};
          n            = n + 2'd1;
        end
      end else begin
        rec.units[n] = code[15:0];
        n            = n + 2'd1;
      end
    end
    if (eos && pv_d) begin
      rec.units[n] = QMark;
      rec.rep[n]   = 1'b1;
      n            = n + 2'd1;
    end
    if (eos) begin
      ph_d = '0;
      pv_d = 1'b0;
    end
    rec.count    = n;
    rec.eos      = eos;
    rec.all_conv = !(err_q || (|rec.rep));
    err_d        = eos ? 1'b0 : (err_q || (|rec.rep));
  end

  assign rec_o  = rec;
  assign push_o = accept_i && (n != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t16_q <= 1'b0;
      pv_q  <= 1'b0;
      ph_q  <= '0;
      err_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        t16_q <= cfg_data_i;
      end
      if (accept_i) begin
        pv_q  <= pv_d;
        ph_q  <= ph_d;
        err_q <= err_d;
      end
    end
  end

endmodule

@@ rtl/core/u2u16_fifo.sv @@
// Short queue of unit groups between the front end and the back end.
module u2u16_fifo #(
  parameter int Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  u2u16_pkg::rec_t push_data_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output u2u16_pkg::rec_t head_o
);
  import u2u16_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  rec_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("queue count out of range");
`endif

endmodule

@@ rtl/core/u2u16_back.sv @@
// Back end: sends the units of each queued group one per cycle, while the output is taken, through the output register.
module u2u16_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  u2u16_pkg::rec_t      head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output u2u16_pkg::out_item_t out_data_o
);
  import u2u16_pkg::*;

  logic      [1:0] idx_q;
  logic            out_valid_q;
  out_item_t       out_q, out_d;
  logic            load, last;

  assign load = !empty_i && (!out_valid_q || out_ready_i);
  assign last = (idx_q == (head_i.count - 2'd1));

  always_comb begin
    out_d.code_unit     = head_i.units[idx_q];
    out_d.replaced      = head_i.rep[idx_q];
    out_d.last_unit     = last;
    out_d.string_done   = last && head_i.eos;
    out_d.all_converted = last && head_i.eos && head_i.all_conv;
  end

  assign pop_o       = load && last;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= last ? 2'd0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.string_done |-> out_data_o.last_unit)
    else $error("string end on a unit that is not the last of its word");
  a_conv_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.all_converted |-> out_data_o.string_done)
    else $error("conversion status outside string end");
  a_rep_is_qmark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.replaced |-> out_data_o.code_unit == QMark)
    else $error("replaced unit is not a question mark");
  a_idx_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> idx_q < head_i.count)
    else $error("unit index beyond group size");
`endif

endmodule

@@ rtl/core/utf32_to_utf16_encoder_unit.sv @@
// Top level of the UTF-32 to UTF-16 encoder: front end, unit-group queue and back end.
// The first unit of an accepted word is written into the queue and then into the output register.
// Throughput: one word per cycle while each word yields one unit and the output is taken; a word
// yielding more units holds the back end, as its single output register sends one unit per cycle.
// The queue of QDepth groups lets the front end keep accepting while the back end drains.
// Reset clears the mode register, the held surrogate, the error flag, the queue pointers and the output valid.
module utf32_to_utf16_encoder_unit #(
  parameter int QDepth = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  u2u16_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output u2u16_pkg::out_item_t out_data_o
);
  import u2u16_pkg::*;

  logic push, pop, full, empty;
  rec_t push_rec, head;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full;

  u2u16_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (in_valid_i && !full),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .rec_o       (push_rec)
  );

  u2u16_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_rec),
    .pop_i       (pop),
    .full_o      (full),
    .empty_o     (empty),
    .head_o      (head)
  );

  u2u16_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ tb/utf32_to_utf16_encoder_unit_test.sv @@
// Testbench for the UTF-32 to UTF-16 encoder: random and directed words, checked unit by unit.
`timescale 1ns / 1ps

module utf32_to_utf16_encoder_unit_test;
  import u2u16_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int LongHold   = 150;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  in_item_t  words_to_send[$];
  out_item_t expected_units[$];
  out_item_t want;

  logic        mode_16bit = 1'b0;
  logic [15:0] held_high = '0;
  logic        held_valid = 1'b0;
  logic        string_error = 1'b0;

  int   words_sent = 0;
  int   words_taken = 0;
  int   mismatches = 0;
  int   cycle_count = 0;
  int   send_wait = 0;
  int   recv_wait = 0;
  int   hold_left = 0;
  logic send_gaps = 1'b1;
  logic recv_gaps = 1'b1;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;

  utf32_to_utf16_encoder_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic out_item_t make_unit(input logic [15:0] unit, input logic rep);
    out_item_t u;
    u = '0;
    u.code_unit = unit;
    u.replaced = rep;
    if (rep) string_error = 1'b1;
    return u;
  endfunction

  // Works out the code units that one accepted word yields and queues them.
  function automatic void encode_word(input in_item_t w);
    out_item_t   units[$];
    logic [31:0] c;
    logic [31:0] v;
    c = w.code_point;
    if (c >= HighFirst && c <= (HighFirst | SurMask)) begin
      if (held_valid) units = {units, make_unit(QMark, 1'b1)};
      held_high = c[15:0];
      held_valid = 1'b1;
    end else if (c >= LowFirst && c <= (LowFirst | SurMask)) begin
      if (!held_valid) begin
        units = {units, make_unit(QMark, 1'b1)};
      end else begin
        units = {units, make_unit(held_high, 1'b0)};
        units = {units, make_unit(c[15:0], 1'b0)};
        held_high = '0;
        held_valid = 1'b0;
      end
    end else begin
      if (held_valid) begin
        units = {units, make_unit(QMark, 1'b1)};
        held_high = '0;
        held_valid = 1'b0;
      end
      if (!mode_16bit && c >= SuppFirst) begin
        if (c > SuppLast) begin
          units = {units, make_unit(QMark, 1'b1)};
        end else begin
          v = c - SuppFirst;
          units = {units, make_unit(HighBase | {6'd0, v[19:10]}, 1'b0)};
          units = {units, make_unit(LowBase | {6'd0, v[9:0]}, 1'b0)};
        end
      end else begin
        units = {units, make_unit(c[15:0], 1'b0)};
      end
    end
    if (w.end_of_string && held_valid) begin
      units = {units, make_unit(QMark, 1'b1)};
      held_high = '0;
      held_valid = 1'b0;
    end
    if (units.size() > 0) begin
      units[units.size() - 1].last_unit = 1'b1;
      if (w.end_of_string) begin
        units[units.size() - 1].string_done = 1'b1;
        units[units.size() - 1].all_converted = ~string_error;
      end
    end
    if (w.end_of_string) begin
      string_error = 1'b0;
      held_high = '0;
      held_valid = 1'b0;
    end
    expected_units = {expected_units, units};
  endfunction

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      send_wait <= 0;
    end else begin
      if (in_valid && in_ready) begin
        encode_word(in_data);
        words_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          send_wait <= send_wait - 1;
          in_valid <= 1'b0;
        end else if (words_to_send.size() > 0) begin
          in_data <= words_to_send.pop_front();
          in_valid <= 1'b1;
          send_wait <= send_gaps ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_units.size() == 0) begin
          $error("unexpected code unit %h", out_data.code_unit);
          mismatches++;
        end else begin
          want = expected_units.pop_front();
          if (out_data.code_unit !== want.code_unit) begin
            $error("code_unit: expected %h, got %h", want.code_unit, out_data.code_unit);
            mismatches++;
          end
          if (out_data.replaced !== want.replaced) begin
            $error("replaced: expected %b, got %b", want.replaced, out_data.replaced);
            mismatches++;
          end
          if (out_data.last_unit !== want.last_unit) begin
            $error("last_unit: expected %b, got %b", want.last_unit, out_data.last_unit);
            mismatches++;
          end
          if (out_data.string_done !== want.string_done) begin
            $error("string_done: expected %b, got %b", want.string_done, out_data.string_done);
            mismatches++;
          end
          if (out_data.all_converted !== want.all_converted) begin
            $error("all_converted: expected %b, got %b", want.all_converted,
                   out_data.all_converted);
            mismatches++;
          end
        end
      end
      if (hold_req && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left <= LongHold;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait <= recv_wait - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_wait <= recv_gaps ? pick_gap() : 0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_word(input logic [31:0] c, input logic eos);
    in_item_t w;
    w.code_point = c;
    w.end_of_string = eos;
    words_to_send = {words_to_send, w};
    words_sent++;
  endtask

  // Mostly well-formed strings; about a quarter of the characters are broken or out of range.
  task automatic add_string(input int chars);
    int          r;
    logic [31:0] c;
    logic        eos;
    for (int i = 0; i < chars; i++) begin
      eos = (i == chars - 1);
      r = $urandom_range(0, 99);
      if (r < 35) begin
        c = $urandom_range(0, 32'hF7FF);
        if (c >= HighFirst) c = c + 32'h0800;
        push_word(c, eos);
      end else if (r < 60) begin
        push_word($urandom_range(SuppFirst, SuppLast), eos);
      end else if (r < 75) begin
        push_word(HighFirst + $urandom_range(0, SurMask), 1'b0);
        push_word(LowFirst + $urandom_range(0, SurMask), eos);
      end else if (r < 80) begin
        push_word(HighFirst + $urandom_range(0, SurMask), eos);
      end else if (r < 85) begin
        push_word(LowFirst + $urandom_range(0, SurMask), eos);
      end else if (r < 90) begin
        push_word($urandom(), eos);
      end else if (r < 95) begin
        c = HighFirst + $urandom_range(0, 32'h07FF);
        c[31:16] = 16'($urandom_range(1, 16'hFFFF));
        push_word(c, eos);
      end else begin
        push_word($urandom_range(32'h0011_0000, 32'hFFFF_FFFF), eos);
      end
    end
  endtask

  task automatic add_random(input int count);
    int target;
    target = words_sent + count;
    while (words_sent < target) add_string($urandom_range(1, 8));
  endtask

  task automatic wait_idle();
    while (words_taken != words_sent || expected_units.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    mode_16bit = m;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    write_mode(1'b0);
    push_word(32'h0000_0000, 1'b0);
    push_word(32'h0000_0041, 1'b0);
    push_word(32'h0000_FFFF, 1'b0);
    push_word(32'h0001_0000, 1'b0);
    push_word(32'h0010_FFFF, 1'b0);
    push_word(32'h0011_0000, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'h0000_D800, 1'b0);
    push_word(32'h0000_DC00, 1'b0);
    push_word(32'h0000_DBFF, 1'b0);
    push_word(32'h0000_DFFF, 1'b1);
    push_word(32'h0000_DC00, 1'b0);
    push_word(32'h0000_D800, 1'b0);
    push_word(32'h0000_DB00, 1'b0);
    push_word(32'h0000_DC55, 1'b0);
    push_word(32'h0000_D9AA, 1'b0);
    push_word(32'h0000_0042, 1'b0);
    push_word(32'h0000_DA00, 1'b1);
    push_word(32'h0000_0061, 1'b1);
    push_word(32'h0001_F600, 1'b1);
    push_word(32'h0000_D800, 1'b0);
    push_word(32'h1234_5678, 1'b1);
    add_random(60);
    wait_idle();

    write_mode(1'b1);
    push_word(32'h0001_D800, 1'b0);
    push_word(32'h0001_0000, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b1);
    send_gaps <= 1'b0;
    recv_gaps <= 1'b0;
    add_random(60);
    wait_idle();

    write_mode(1'b0);
    hold_req <= 1'b1;
    recv_gaps <= 1'b1;
    add_random(60);
    wait_idle();
    send_gaps <= 1'b1;

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
